### rtl/pdm_pkg.sv
// Shared widths, payload structs and register indexes for the PID drive mixer.
package pdm_pkg;

  // Field and datapath widths.
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned DIFF_W     = ERR_W + 1;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned P_TERM_W   = GAIN_W + 1 + ERR_W;
  localparam int unsigned I_TERM_W   = GAIN_W + 1 + SUM_W;
  localparam int unsigned D_TERM_W   = GAIN_W + 1 + DIFF_W;
  localparam int unsigned PID_W      = I_TERM_W + 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DRIVE_W    = PID_W - FRAC_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [GAIN_W-1:0] KI_RESET = 16'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_BASE = 3'd3,
    CFG_STOP = 3'd4
  } cfg_idx_e;

  // Gain registers as seen by the product stage.
  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } pdm_gains_t;

  // Error terms of one item after the state update.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } pdm_terms_t;

  // Weighted terms of one item.
  typedef struct packed {
    logic signed [P_TERM_W-1:0] p_term;
    logic signed [I_TERM_W-1:0] i_term;
    logic signed [D_TERM_W-1:0] d_term;
  } pdm_products_t;

endpackage

### rtl/pid_differential_drive_mixer_unit.sv
// Top level of the PID steering mixer: configuration registers and the four-stage pipeline.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  shift_error_i (signed Q8.8)
//   output   out        out_valid_o / out_stall_i left_speed_o, right_speed_o
//   config   in         cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled; each item passes in order through
// the registers of error update, gain products, PID sum, and wheel mix and clamp.
// Reset clears the error sum, the previous error and all gains except ki, which is 3.
// Each stage holds its item while the next one is full and stalled; empty stages
// still fill, so the input stalls only when all four stages are occupied.
// An item under manual stop updates the controller state and yields no result.
module pid_differential_drive_mixer_unit #(
  parameter int unsigned MAX_SPEED = 100
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pdm_pkg::ERR_W-1:0]    shift_error_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pdm_pkg::SPEED_W-1:0]         left_speed_o,
  output logic [pdm_pkg::SPEED_W-1:0]         right_speed_o,
  input  logic                                cfg_we_i,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pdm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  pdm_pkg::pdm_gains_t                   gains_q;
  logic [pdm_pkg::SPEED_W-1:0]           base_speed_q;
  logic                                  manual_stop_q;
  pdm_pkg::pdm_terms_t                   terms;
  pdm_pkg::pdm_products_t                products;
  logic                                  front_valid;
  logic                                  mult_ready;
  logic                                  mult_valid;
  logic                                  mix_ready;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp    <= '0;
      gains_q.ki    <= pdm_pkg::KI_RESET;
      gains_q.kd    <= '0;
      base_speed_q  <= '0;
      manual_stop_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (pdm_pkg::cfg_idx_e'(cfg_idx_i))
        pdm_pkg::CFG_KP:   gains_q.kp    <= cfg_data_i;
        pdm_pkg::CFG_KI:   gains_q.ki    <= cfg_data_i;
        pdm_pkg::CFG_KD:   gains_q.kd    <= cfg_data_i;
        pdm_pkg::CFG_BASE: base_speed_q  <= cfg_data_i[pdm_pkg::SPEED_W-1:0];
        pdm_pkg::CFG_STOP: manual_stop_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Error update and term register.
  pdm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .shift_error_i (shift_error_i),
    .manual_stop_i (manual_stop_q),
    .ready_i       (mult_ready),
    .in_stall_o    (in_stall_o),
    .valid_o       (front_valid),
    .terms_o       (terms)
  );

  // Gain products.
  pdm_mult u_mult (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (front_valid),
    .terms_i    (terms),
    .gains_i    (gains_q),
    .ready_o    (mult_ready),
    .ready_i    (mix_ready),
    .valid_o    (mult_valid),
    .products_o (products)
  );

  // PID sum, wheel mix and output register.
  pdm_mix #(
    .MAX_SPEED (MAX_SPEED)
  ) u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (mult_valid),
    .products_i    (products),
    .base_speed_i  (base_speed_q),
    .ready_o       (mix_ready),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o)
  );

endmodule

### rtl/pdm_front.sv
// Input stage: integral and derivative state update and the error term register.
module pdm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic signed [pdm_pkg::ERR_W-1:0]    shift_error_i,
  input  logic                                manual_stop_i,
  input  logic                                ready_i,
  output logic                                in_stall_o,
  output logic                                valid_o,
  output pdm_pkg::pdm_terms_t                 terms_o
);

  logic                                  valid_q;
  pdm_pkg::pdm_terms_t                   terms_q;
  logic signed [pdm_pkg::SUM_W-1:0]      sum_q;
  logic signed [pdm_pkg::SUM_W-1:0]      sum_d;
  logic signed [pdm_pkg::ERR_W-1:0]      prev_q;
  logic signed [pdm_pkg::SUM_W:0]        sum_wide;
  logic signed [pdm_pkg::DIFF_W-1:0]     diff;
  logic                                  ready_up;
  logic                                  accept;

  // The stage takes an item when it is empty or its item moves on.
  assign ready_up   = !valid_q || ready_i;
  assign accept     = in_valid_i && ready_up;
  assign in_stall_o = !ready_up;

  // Saturating running sum of the error.
  always_comb begin
    sum_wide = {sum_q[pdm_pkg::SUM_W-1], sum_q}
             + {{(pdm_pkg::SUM_W+1-pdm_pkg::ERR_W){shift_error_i[pdm_pkg::ERR_W-1]}},
                shift_error_i};
    if (sum_wide[pdm_pkg::SUM_W] != sum_wide[pdm_pkg::SUM_W-1]) begin
      sum_d = sum_wide[pdm_pkg::SUM_W] ? {1'b1, {(pdm_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(pdm_pkg::SUM_W-1){1'b1}}};
    end else begin
      sum_d = sum_wide[pdm_pkg::SUM_W-1:0];
    end
  end

  // Difference to the previous error.
  assign diff = {shift_error_i[pdm_pkg::ERR_W-1], shift_error_i}
              - {prev_q[pdm_pkg::ERR_W-1], prev_q};

  // Controller state advances on every accepted item, stopped or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (accept) begin
      sum_q  <= sum_d;
      prev_q <= shift_error_i;
    end
  end

  // An item under manual stop leaves no entry in the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= accept && !manual_stop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      terms_q.err  <= shift_error_i;
      terms_q.sum  <= sum_d;
      terms_q.diff <= diff;
    end
  end

  assign valid_o = valid_q;
  assign terms_o = terms_q;

  // A stopped item never reaches the next stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && manual_stop_i |=> !valid_q)
    else $error("stopped item entered the pipeline");

  // Adding a non-negative error to a non-negative sum must not wrap negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !shift_error_i[pdm_pkg::ERR_W-1] && !sum_q[pdm_pkg::SUM_W-1]
    |=> !sum_q[pdm_pkg::SUM_W-1])
    else $error("error sum wrapped instead of saturating");

endmodule

### rtl/pdm_mult.sv
// Product stage: the three gain multiplications, each into its own register.
module pdm_mult (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  pdm_pkg::pdm_terms_t    terms_i,
  input  pdm_pkg::pdm_gains_t    gains_i,
  output logic                   ready_o,
  input  logic                   ready_i,
  output logic                   valid_o,
  output pdm_pkg::pdm_products_t products_o
);

  logic                                  valid_q;
  pdm_pkg::pdm_products_t                products_q;
  logic signed [pdm_pkg::P_TERM_W-1:0]   p_d;
  logic signed [pdm_pkg::I_TERM_W-1:0]   i_d;
  logic signed [pdm_pkg::D_TERM_W-1:0]   d_d;
  logic                                  ready_up;
  logic                                  accept;

  assign ready_up = !valid_q || ready_i;
  assign accept   = valid_i && ready_up;
  assign ready_o  = ready_up;

  // Unsigned gains get a zero sign bit before the signed multiply.
  assign p_d = $signed({1'b0, gains_i.kp}) * terms_i.err;
  assign i_d = $signed({1'b0, gains_i.ki}) * terms_i.sum;
  assign d_d = $signed({1'b0, gains_i.kd}) * terms_i.diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_up) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      products_q.p_term <= p_d;
      products_q.i_term <= i_d;
      products_q.d_term <= d_d;
    end
  end

  assign valid_o    = valid_q;
  assign products_o = products_q;

endmodule

### rtl/pdm_mix.sv
// Sum and mix stages: PID sum, truncation to a drive value, wheel mixing and clamp.
module pdm_mix #(
  parameter int unsigned MAX_SPEED = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  pdm_pkg::pdm_products_t            products_i,
  input  logic [pdm_pkg::SPEED_W-1:0]       base_speed_i,
  output logic                              ready_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [pdm_pkg::SPEED_W-1:0]       left_speed_o,
  output logic [pdm_pkg::SPEED_W-1:0]       right_speed_o
);

  localparam int unsigned WheelW = pdm_pkg::DRIVE_W + 1;
  localparam logic [pdm_pkg::SPEED_W-1:0] MaxSpeedL = pdm_pkg::SPEED_W'(MAX_SPEED);

  logic                                  c_valid_q;
  logic signed [pdm_pkg::PID_W-1:0]      pid_q;
  logic signed [pdm_pkg::PID_W-1:0]      pid_d;
  logic                                  out_valid_q;
  logic [pdm_pkg::SPEED_W-1:0]           left_q;
  logic [pdm_pkg::SPEED_W-1:0]           right_q;
  logic [pdm_pkg::SPEED_W-1:0]           left_d;
  logic [pdm_pkg::SPEED_W-1:0]           right_d;
  logic                                  round_up;
  logic signed [pdm_pkg::DRIVE_W-1:0]    drive;
  logic signed [WheelW-1:0]              left_w;
  logic signed [WheelW-1:0]              right_w;
  logic                                  out_ready;
  logic                                  c_ready;

  // Clamp a signed wheel value into 0..MAX_SPEED.
  function automatic logic [pdm_pkg::SPEED_W-1:0] clamp_wheel(
    input logic signed [WheelW-1:0] v
  );
    logic [pdm_pkg::SPEED_W-1:0] r;
    if (v[WheelW-1]) begin
      r = '0;
    end else if (v > $signed({{(WheelW-pdm_pkg::SPEED_W){1'b0}}, MaxSpeedL})) begin
      r = MaxSpeedL;
    end else begin
      r = v[pdm_pkg::SPEED_W-1:0];
    end
    return r;
  endfunction

  assign out_ready = !out_valid_q || !out_stall_i;
  assign c_ready   = !c_valid_q || out_ready;
  assign ready_o   = c_ready;

  // PID sum of the three weighted terms; it cannot overflow PID_W bits.
  assign pid_d = pdm_pkg::PID_W'(products_i.p_term)
               + pdm_pkg::PID_W'(products_i.i_term)
               + pdm_pkg::PID_W'(products_i.d_term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && c_ready) begin
      pid_q <= pid_d;
    end
  end

  // Drop the fraction toward zero: a negative sum with a fraction rounds up.
  assign round_up = pid_q[pdm_pkg::PID_W-1] && (|pid_q[pdm_pkg::FRAC_W-1:0]);
  assign drive    = $signed(pid_q[pdm_pkg::PID_W-1:pdm_pkg::FRAC_W]
                          + {{(pdm_pkg::DRIVE_W-1){1'b0}}, round_up});

  // Left wheel gets base plus drive, right wheel base minus drive.
  assign left_w  = $signed({{(WheelW-pdm_pkg::SPEED_W){1'b0}}, base_speed_i})
                 + {drive[pdm_pkg::DRIVE_W-1], drive};
  assign right_w = $signed({{(WheelW-pdm_pkg::SPEED_W){1'b0}}, base_speed_i})
                 - {drive[pdm_pkg::DRIVE_W-1], drive};

  // Zero base speed stops both wheels.
  always_comb begin
    if (base_speed_i == '0) begin
      left_d  = '0;
      right_d = '0;
    end else begin
      left_d  = clamp_wheel(left_w);
      right_d = clamp_wheel(right_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_q && out_ready) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;

  // Delivered wheel speeds never exceed the speed limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (left_q <= MaxSpeedL) && (right_q <= MaxSpeedL))
    else $error("wheel speed above limit");

  // A summed item held behind a full output register is kept, not dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && !out_ready |=> c_valid_q)
    else $error("summed item lost while output stalled");

endmodule
